// ----- rtl/swsfr_pkg.sv -----
// Shared types and codes for the single-wire sensor frame receiver.
// No dependencies; used by the top level and its checker.
package swsfr_pkg;

  // Item modes
  localparam logic [1:0] MODE_TICK    = 2'd0;
  localparam logic [1:0] MODE_EDGE    = 2'd1;
  localparam logic [1:0] MODE_RESTART = 2'd2;
  localparam logic [1:0] MODE_TIMEOUT = 2'd3;

  // Phase codes as shown on the result word
  localparam logic [1:0] PHASE_IDLE  = 2'd0;
  localparam logic [1:0] PHASE_START = 2'd1;
  localparam logic [1:0] PHASE_RECV  = 2'd2;
  localparam logic [1:0] PHASE_END   = 2'd3;

  // Read status codes
  localparam logic [1:0] STATUS_UNKNOWN = 2'd0;
  localparam logic [1:0] STATUS_OK      = 2'd1;
  localparam logic [1:0] STATUS_BAD     = 2'd2;

  // Configuration register indexes
  localparam logic [1:0] REG_BIT_THRESHOLD = 2'd0;
  localparam logic [1:0] REG_IDLE_PERIOD   = 2'd1;
  localparam logic [1:0] REG_START_LOW     = 2'd2;

  // Frame layout
  localparam logic [1:0] PREAMBLE_EDGES = 2'd2;
  localparam logic [5:0] FRAME_BITS     = 6'd40;
  localparam logic [3:0] BYTE_BITS      = 4'd8;
  localparam logic [2:0] DATA_BYTES     = 3'd4;

  // Register reset values
  localparam logic [7:0]  BIT_THRESHOLD_RST = 8'd100;
  localparam logic [15:0] IDLE_PERIOD_RST   = 16'd2000;
  localparam logic [7:0]  START_LOW_RST     = 8'd2;

  typedef enum logic [3:0] {
    PH_IDLE  = 4'b0001,
    PH_START = 4'b0010,
    PH_RECV  = 4'b0100,
    PH_END   = 4'b1000
  } phase_t;

  typedef struct packed {
    logic [1:0] mode;
    logic [7:0] interval_us;
  } item_t;

  typedef struct packed {
    logic        line_low;
    logic        listening;
    logic [1:0]  phase;
    logic [1:0]  read_status;
    logic [31:0] data_word;
    logic [7:0]  checksum_byte;
  } result_t;

endpackage

// ----- rtl/single_wire_sensor_frame_receiver.sv -----
// Master-side receiver for a single-wire temperature/humidity sensor frame.
// Depends on swsfr_pkg for item/result types, phase and status codes.
//
// Usage:
//   Item channel (item_valid/item_stall/item) carries one word per event:
//   a millisecond tick, a falling edge with its measured interval, a
//   restart, or a timeout abort. Every accepted word yields exactly one
//   result word on the result channel (result_valid/result_stall/result)
//   showing line drive, phase, read status, data bytes and checksum.
//   Configuration (bit threshold, idle period, start pulse length) is
//   written through cfg_valid/cfg_ready/cfg_index/cfg_data; cfg_ready is
//   always high and writes belong to idle periods.
//
// Timing: a word accepted at one clock edge is captured in the input
//   register; the frame state and the output register are updated from it
//   together once the output can advance, one word per cycle sustained
//   while the result channel does not stall. The single state update per
//   cycle sets this rate.
// Reset (rst, synchronous) clears both registers' valid flags, returns the
//   frame state to idle and loads the configuration defaults. When the
//   receiver stalls, the output register holds its word, the input register
//   holds the next one, and item_stall rises once both are occupied.
module single_wire_sensor_frame_receiver
  import swsfr_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  input  logic        item_valid,
  output logic        item_stall,
  input  item_t       item,
  output logic        result_valid,
  input  logic        result_stall,
  output result_t     result,
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [1:0]  cfg_index,
  input  logic [15:0] cfg_data
);

  // Configuration
  logic [7:0]  bit_threshold_us;
  logic [15:0] idle_period_ms;
  logic [7:0]  start_low_ms;

  // Input register
  logic  hold_valid;
  item_t hold;

  // Frame state
  phase_t      phase_reg, phase_reg_next;
  logic [15:0] elapsed_ms, elapsed_ms_next;
  logic [1:0]  preamble_left, preamble_left_next;
  logic [5:0]  bits_left, bits_left_next;
  logic [7:0]  shift_byte, shift_byte_next;
  logic [3:0]  bits_in_byte_left, bits_in_byte_left_next;
  logic [2:0]  byte_count, byte_count_next;
  logic [7:0]  running_sum, running_sum_next;
  logic [31:0] data_store, data_store_next;
  logic [1:0]  status_reg, status_reg_next;

  logic    advance;
  result_t result_next;
  logic [16:0] start_end_ms;

  assign cfg_ready  = 1'b1;
  assign advance    = !result_valid || !result_stall;
  assign item_stall = hold_valid && !advance;

  always_ff @(posedge clk) begin
    if (rst) begin
      bit_threshold_us <= BIT_THRESHOLD_RST;
      idle_period_ms   <= IDLE_PERIOD_RST;
      start_low_ms     <= START_LOW_RST;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        REG_BIT_THRESHOLD: bit_threshold_us <= cfg_data[7:0];
        REG_IDLE_PERIOD:   idle_period_ms   <= cfg_data;
        REG_START_LOW:     start_low_ms     <= cfg_data[7:0];
        default: ;
      endcase
    end
  end

  // Input register: load whenever it is empty or draining this cycle
  always_ff @(posedge clk) begin
    if (rst) begin
      hold_valid <= 1'b0;
    end else if (!item_stall) begin
      hold_valid <= item_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (!item_stall && item_valid) begin
      hold <= item;
    end
  end

  assign start_end_ms = {1'b0, idle_period_ms} + {9'd0, start_low_ms};

  always_comb begin
    phase_reg_next         = phase_reg;
    elapsed_ms_next        = elapsed_ms;
    preamble_left_next     = preamble_left;
    bits_left_next         = bits_left;
    shift_byte_next        = shift_byte;
    bits_in_byte_left_next = bits_in_byte_left;
    byte_count_next        = byte_count;
    running_sum_next       = running_sum;
    data_store_next        = data_store;
    status_reg_next        = status_reg;

    case (hold.mode)
      MODE_TICK: begin
        if (elapsed_ms != 16'hFFFF) begin
          elapsed_ms_next = elapsed_ms + 16'd1;
        end
        case (phase_reg)
          PH_IDLE: begin
            if (elapsed_ms_next > idle_period_ms) begin
              phase_reg_next         = PH_START;
              preamble_left_next     = PREAMBLE_EDGES;
              bits_left_next         = FRAME_BITS;
              bits_in_byte_left_next = BYTE_BITS;
              shift_byte_next        = 8'd0;
              byte_count_next        = 3'd0;
              running_sum_next       = 8'd0;
            end
          end
          PH_START: begin
            if ({1'b0, elapsed_ms_next} > start_end_ms) begin
              phase_reg_next  = PH_RECV;
              status_reg_next = STATUS_UNKNOWN;
            end
          end
          default: ;
        endcase
      end
      MODE_EDGE: begin
        if (phase_reg == PH_RECV) begin
          if (preamble_left != 2'd0) begin
            // skip the sensor's response edges
            preamble_left_next = preamble_left - 2'd1;
          end else begin
            shift_byte_next = {shift_byte[6:0], (hold.interval_us > bit_threshold_us)};
            bits_in_byte_left_next = bits_in_byte_left - 4'd1;
            if (bits_in_byte_left_next == 4'd0) begin
              bits_in_byte_left_next = BYTE_BITS;
              if (byte_count < DATA_BYTES) begin
                running_sum_next = running_sum + shift_byte_next;
                case (byte_count[1:0])
                  2'd0:    data_store_next[31:24] = shift_byte_next;
                  2'd1:    data_store_next[23:16] = shift_byte_next;
                  2'd2:    data_store_next[15:8]  = shift_byte_next;
                  default: data_store_next[7:0]   = shift_byte_next;
                endcase
                byte_count_next = byte_count + 3'd1;
              end
            end
            bits_left_next = bits_left - 6'd1;
            if (bits_left_next == 6'd0) begin
              status_reg_next = (running_sum_next == shift_byte_next) ? STATUS_OK : STATUS_BAD;
              phase_reg_next  = PH_END;
            end
          end
        end
      end
      MODE_RESTART: begin
        phase_reg_next  = PH_IDLE;
        elapsed_ms_next = 16'd0;
      end
      default: begin
        if (phase_reg == PH_START || phase_reg == PH_RECV) begin
          phase_reg_next  = PH_END;
          status_reg_next = STATUS_UNKNOWN;
        end
      end
    endcase
  end

  always_comb begin
    result_next.line_low    = (phase_reg_next == PH_START);
    result_next.listening   = (phase_reg_next == PH_RECV);
    case (phase_reg_next)
      PH_IDLE:  result_next.phase = PHASE_IDLE;
      PH_START: result_next.phase = PHASE_START;
      PH_RECV:  result_next.phase = PHASE_RECV;
      default:  result_next.phase = PHASE_END;
    endcase
    result_next.read_status = status_reg_next;
    result_next.data_word   = data_store_next;
    // checksum is shown only for a completed frame
    result_next.checksum_byte =
      (phase_reg_next == PH_END && status_reg_next != STATUS_UNKNOWN) ? shift_byte_next : 8'd0;
  end

  wire step = hold_valid && advance;

  always_ff @(posedge clk) begin
    if (rst) begin
      phase_reg         <= PH_IDLE;
      elapsed_ms        <= 16'd0;
      preamble_left     <= PREAMBLE_EDGES;
      bits_left         <= FRAME_BITS;
      shift_byte        <= 8'd0;
      bits_in_byte_left <= BYTE_BITS;
      byte_count        <= 3'd0;
      running_sum       <= 8'd0;
      data_store        <= 32'd0;
      status_reg        <= STATUS_UNKNOWN;
    end else if (step) begin
      phase_reg         <= phase_reg_next;
      elapsed_ms        <= elapsed_ms_next;
      preamble_left     <= preamble_left_next;
      bits_left         <= bits_left_next;
      shift_byte        <= shift_byte_next;
      bits_in_byte_left <= bits_in_byte_left_next;
      byte_count        <= byte_count_next;
      running_sum       <= running_sum_next;
      data_store        <= data_store_next;
      status_reg        <= status_reg_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      result_valid <= 1'b0;
    end else if (advance) begin
      result_valid <= hold_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (step) begin
      result <= result_next;
    end
  end

endmodule

// ----- rtl/swsfr_checker.sv -----
// Port-level checks for the single-wire sensor frame receiver.
// Depends on swsfr_pkg; bound to single_wire_sensor_frame_receiver below.
module swsfr_checker
  import swsfr_pkg::*;
(
  input logic    clk,
  input logic    rst,
  input logic    item_valid,
  input logic    item_stall,
  input logic    result_valid,
  input logic    result_stall,
  input result_t result
);

  // Hold a stalled result word
  a_result_hold: assert property (@(posedge clk) disable iff (rst)
    result_valid && result_stall |=> result_valid && $stable(result))
    else $error("stalled result word changed");

  // Drive the line low exactly in the start phase
  a_line_low_phase: assert property (@(posedge clk) disable iff (rst)
    result_valid |-> (result.line_low == (result.phase == PHASE_START)) &&
                     (result.listening == (result.phase == PHASE_RECV)))
    else $error("line drive flags disagree with phase");

  // A nonzero checksum only appears on a finished, checked frame
  a_checksum_end: assert property (@(posedge clk) disable iff (rst)
    result_valid && result.checksum_byte != 8'd0 |->
      result.phase == PHASE_END &&
      (result.read_status == STATUS_OK || result.read_status == STATUS_BAD))
    else $error("checksum shown outside a completed frame");

  // Status is unknown while listening
  a_recv_status: assert property (@(posedge clk) disable iff (rst)
    result_valid && result.phase == PHASE_RECV |-> result.read_status == STATUS_UNKNOWN)
    else $error("status set while still receiving");

  // An accepted word with an idle output reaches the output once it leaves the input register
  a_latency: assert property (@(posedge clk) disable iff (rst)
    item_valid && !item_stall && !result_valid ##1 !result_stall |=> result_valid)
    else $error("accepted word did not reach the output");

endmodule

bind single_wire_sensor_frame_receiver swsfr_checker u_swsfr_checker (
  .clk          (clk),
  .rst          (rst),
  .item_valid   (item_valid),
  .item_stall   (item_stall),
  .result_valid (result_valid),
  .result_stall (result_stall),
  .result       (result)
);

// ----- dv/tb_single_wire_sensor_frame_receiver.sv -----
// Self-checking bench for the single-wire sensor frame receiver.
// Drives line-event words, predicts every readout word in-bench and compares
// in order; depends on swsfr_pkg and single_wire_sensor_frame_receiver.
module tb_single_wire_sensor_frame_receiver;
  import swsfr_pkg::*;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        item_valid = 1'b0;
  logic        item_stall;
  item_t       item_word = '0;
  logic        result_valid;
  logic        result_stall = 1'b0;
  result_t     result_word;
  logic        cfg_valid = 1'b0;
  logic        cfg_ready;
  logic [1:0]  cfg_index = '0;
  logic [15:0] cfg_data = '0;

  single_wire_sensor_frame_receiver DUT (
    .clk          (clk),
    .rst          (rst),
    .item_valid   (item_valid),
    .item_stall   (item_stall),
    .item         (item_word),
    .result_valid (result_valid),
    .result_stall (result_stall),
    .result       (result_word),
    .cfg_valid    (cfg_valid),
    .cfg_ready    (cfg_ready),
    .cfg_index    (cfg_index),
    .cfg_data     (cfg_data)
  );

  always #5 clk = ~clk;

  // Bench copy of the configuration
  logic [7:0]  thr_cfg   = BIT_THRESHOLD_RST;
  logic [15:0] idle_cfg  = IDLE_PERIOD_RST;
  logic [7:0]  start_cfg = START_LOW_RST;

  // Bench copy of the frame state
  logic [1:0]  ph             = PHASE_IDLE;
  logic [15:0] elapsed        = '0;
  logic [1:0]  preamble       = PREAMBLE_EDGES;
  logic [5:0]  bits_left      = FRAME_BITS;
  logic [7:0]  shreg          = '0;
  logic [3:0]  byte_bits_left = BYTE_BITS;
  logic [2:0]  nbytes         = '0;
  logic [7:0]  sum            = '0;
  logic [31:0] data           = '0;
  logic [1:0]  status         = STATUS_UNKNOWN;

  item_t   line_events[$];
  result_t pending_readouts[$];

  int send_idle_pct  = 31;
  int recv_stall_pct = 87;
  int items_queued, events_accepted, readouts_seen, input_held;
  int frames_ok, frames_bad, aborts, mismatches;
  int hold_left = 0;
  bit hold_req = 1'b0;
  bit hold_done = 1'b0;

  function automatic result_t sensor_read_step(item_t w);
    result_t r;
    case (w.mode)
      MODE_TICK: begin
        if (elapsed != 16'hFFFF) elapsed++;
        if (ph == PHASE_IDLE) begin
          if (elapsed > idle_cfg) begin
            ph             = PHASE_START;
            preamble       = PREAMBLE_EDGES;
            bits_left      = FRAME_BITS;
            byte_bits_left = BYTE_BITS;
            shreg          = '0;
            nbytes         = '0;
            sum            = '0;
          end
        end else if (ph == PHASE_START) begin
          // compare at 17 bits so a start end past the counter range is never met
          if ({1'b0, elapsed} > {1'b0, idle_cfg} + start_cfg) begin
            ph     = PHASE_RECV;
            status = STATUS_UNKNOWN;
          end
        end
      end
      MODE_EDGE: begin
        if (ph == PHASE_RECV) begin
          if (preamble != 0) preamble--;
          else begin
            shreg = {shreg[6:0], w.interval_us > thr_cfg};
            byte_bits_left--;
            if (byte_bits_left == 0) begin
              byte_bits_left = BYTE_BITS;
              if (nbytes < DATA_BYTES) begin
                sum = sum + shreg;
                data[24 - 8 * nbytes +: 8] = shreg;
                nbytes++;
              end
            end
            bits_left--;
            if (bits_left == 0) begin
              status = (sum == shreg) ? STATUS_OK : STATUS_BAD;
              ph     = PHASE_END;
              if (status == STATUS_OK) frames_ok++;
              else frames_bad++;
            end
          end
        end
      end
      MODE_RESTART: begin
        ph      = PHASE_IDLE;
        elapsed = '0;
      end
      MODE_TIMEOUT: begin
        if (ph == PHASE_START || ph == PHASE_RECV) begin
          ph     = PHASE_END;
          status = STATUS_UNKNOWN;
          aborts++;
        end
      end
    endcase
    r.line_low      = (ph == PHASE_START);
    r.listening     = (ph == PHASE_RECV);
    r.phase         = ph;
    r.read_status   = status;
    r.data_word     = data;
    r.checksum_byte = (ph == PHASE_END && status != STATUS_UNKNOWN) ? shreg : 8'h00;
    return r;
  endfunction

  // Driver: offer queued words, predict each one at acceptance
  always @(posedge clk) begin
    if (rst) begin
      item_valid <= 1'b0;
      item_word  <= '0;
    end else begin
      if (item_valid && item_stall) input_held++;
      if (item_valid && !item_stall) begin
        pending_readouts.push_back(sensor_read_step(item_word));
        events_accepted++;
      end
      if (!item_valid || !item_stall) begin
        if (line_events.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
          item_word  <= line_events.pop_front();
          item_valid <= 1'b1;
        end else
          item_valid <= 1'b0;
      end
    end
  end

  // Long receiver hold-off, armed once from the stimulus
  always @(posedge clk) begin
    if (rst) hold_left <= 0;
    else if (hold_req && !hold_done) begin
      hold_left <= 150;
      hold_done <= 1'b1;
    end else if (hold_left != 0)
      hold_left <= hold_left - 1;
  end

  // Monitor: compare each readout word with the oldest prediction
  always @(posedge clk) begin
    result_t exp_r;
    if (rst) result_stall <= 1'b0;
    else begin
      if (result_valid && !result_stall) begin
        readouts_seen++;
        if (pending_readouts.size() == 0) begin
          mismatches++;
          if (mismatches <= 10)
            $display("unexpected readout word %h with nothing predicted", result_word);
        end else begin
          exp_r = pending_readouts.pop_front();
          if (result_word.line_low !== exp_r.line_low ||
              result_word.listening !== exp_r.listening ||
              result_word.phase !== exp_r.phase ||
              result_word.read_status !== exp_r.read_status ||
              result_word.data_word !== exp_r.data_word ||
              result_word.checksum_byte !== exp_r.checksum_byte) begin
            mismatches++;
            if (mismatches <= 10) begin
              $display("readout %0d mismatch (exp/got): line_low %0b/%0b listening %0b/%0b",
                       readouts_seen, exp_r.line_low, result_word.line_low,
                       exp_r.listening, result_word.listening);
              $display("  phase %0d/%0d status %0d/%0d data %h/%h checksum %h/%h",
                       exp_r.phase, result_word.phase,
                       exp_r.read_status, result_word.read_status,
                       exp_r.data_word, result_word.data_word,
                       exp_r.checksum_byte, result_word.checksum_byte);
            end
          end
        end
      end
      result_stall <= (hold_left != 0) || ($urandom_range(99) < recv_stall_pct);
    end
  end

  task automatic queue_event(input logic [1:0] m, input logic [7:0] iv);
    item_t w;
    w.mode        = m;
    w.interval_us = iv;
    line_events.push_back(w);
    items_queued++;
  endtask

  function automatic logic [7:0] edge_interval(input logic one);
    if (!one) return 8'($urandom_range(thr_cfg, 0));
    if (thr_cfg == 8'hFF) return 8'hFF;
    return 8'($urandom_range(255, thr_cfg + 1));
  endfunction

  // Restart, tick through idle and start pulse, then preamble and 40 bit edges.
  // A cut in 0..39 breaks the frame off before that data edge.
  task automatic queue_frame(input bit good_sum, input int cut);
    logic [39:0] frame;
    logic [7:0]  csum;
    frame[39:8] = $urandom;
    csum = frame[39:32] + frame[31:24] + frame[23:16] + frame[15:8];
    frame[7:0] = good_sum ? csum : 8'($urandom);
    queue_event(MODE_RESTART, 8'($urandom));
    repeat (idle_cfg + start_cfg + 2) queue_event(MODE_TICK, 8'($urandom));
    repeat (2) queue_event(MODE_EDGE, 8'($urandom));
    for (int i = 39; i >= 0; i--) begin
      if (39 - i == cut) begin
        queue_event($urandom_range(1) ? MODE_TIMEOUT : MODE_RESTART, 8'($urandom));
        return;
      end
      queue_event(MODE_EDGE, edge_interval(frame[i]));
    end
  endtask

  task automatic random_phase(input int budget);
    int stop;
    stop = items_queued + budget;
    while (items_queued < stop) begin
      case ($urandom_range(9))
        0, 1: queue_frame($urandom_range(1), $urandom_range(39));
        2: repeat ($urandom_range(6, 1)) queue_event(2'($urandom), 8'($urandom));
        default: queue_frame($urandom_range(2) != 0, -1);
      endcase
    end
  endtask

  task automatic wait_drained();
    do @(negedge clk);
    while (line_events.size() != 0 || item_valid || pending_readouts.size() != 0);
  endtask

  task automatic write_reg(input logic [1:0] idx, input logic [15:0] val);
    @(posedge clk);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    do @(posedge clk);
    while (!cfg_ready);
    cfg_valid <= 1'b0;
    case (idx)
      REG_BIT_THRESHOLD: thr_cfg   = val[7:0];
      REG_IDLE_PERIOD:   idle_cfg  = val;
      REG_START_LOW:     start_cfg = val[7:0];
      default: ;
    endcase
  endtask

  task automatic configure(input logic [7:0] thr, input logic [15:0] idle,
                           input logic [7:0] start_low);
    wait_drained();
    write_reg(REG_BIT_THRESHOLD, {8'h00, thr});
    write_reg(REG_IDLE_PERIOD, idle);
    write_reg(REG_START_LOW, {8'h00, start_low});
    @(negedge clk);
  endtask

  initial begin
    repeat (11) @(posedge clk);
    rst <= 1'b0;

    // Directed: ignored words, every phase change, aborts and restarts
    configure(8'd0, 16'd0, 8'd0);
    queue_event(MODE_EDGE, 8'hFF);
    queue_event(MODE_TIMEOUT, 8'h00);
    queue_event(MODE_TICK, 8'h00);
    queue_event(MODE_EDGE, 8'hFF);
    queue_event(MODE_TICK, 8'hFF);
    queue_event(MODE_EDGE, 8'h00);
    queue_event(MODE_EDGE, 8'hFF);
    queue_event(MODE_EDGE, 8'hFF);
    queue_event(MODE_EDGE, 8'h00);
    queue_event(MODE_TIMEOUT, 8'hFF);
    queue_event(MODE_TICK, 8'h00);
    queue_event(MODE_EDGE, 8'h80);
    queue_event(MODE_TIMEOUT, 8'h00);
    queue_event(MODE_RESTART, 8'h55);
    queue_event(MODE_TICK, 8'hAA);
    queue_event(MODE_TIMEOUT, 8'h00);
    queue_event(MODE_RESTART, 8'h00);
    queue_event(MODE_TICK, 8'h00);
    queue_event(MODE_TICK, 8'h00);
    queue_event(MODE_RESTART, 8'hFF);
    queue_event(MODE_RESTART, 8'h00);

    // Threshold extremes and the longest start pulse
    configure(8'd255, 16'd0, 8'd255);
    queue_frame(1'b1, -1);
    configure(8'd0, 16'd1, 8'd0);
    queue_frame(1'b1, -1);
    queue_frame(1'b0, -1);

    configure(8'($urandom), 16'($urandom_range(6)), 8'($urandom_range(3)));
    random_phase(120);

    wait_drained();
    send_idle_pct  = 87;
    recv_stall_pct = 31;
    configure(8'($urandom), 16'($urandom_range(6)), 8'($urandom_range(3)));
    random_phase(120);

    wait_drained();
    send_idle_pct  = 0;
    recv_stall_pct = 0;
    configure(8'($urandom), 16'($urandom_range(6)), 8'($urandom_range(3)));
    hold_req = 1'b1;
    random_phase(120);

    // Idle period at the top of the counter range: idle is never left
    configure(8'd100, 16'd65535, 8'd255);
    repeat (5) queue_event(MODE_TICK, 8'h00);
    queue_event(MODE_TIMEOUT, 8'h00);
    queue_event(MODE_RESTART, 8'h00);

    wait_drained();
    repeat (8) @(posedge clk);
    $display("run covered %0d line words and %0d readouts: %0d frames with good checksum,",
             events_accepted, readouts_seen, frames_ok);
    $display("%0d with bad checksum, %0d aborted reads, input held off in %0d cycles",
             frames_bad, aborts, input_held);
    if (mismatches == 0 && pending_readouts.size() == 0)
      $display("single_wire_sensor_frame_receiver regression: pass");
    else
      $display("single_wire_sensor_frame_receiver regression: fail");
    $finish;
  end

  initial begin
    #20000000;
    $display("single_wire_sensor_frame_receiver regression: fail");
    $finish;
  end

endmodule
